@@ design/cc20_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cc20_pkg
// Types, constants and round functions shared by the ChaCha20 stream cipher.
// ----------------------------------------------------------------------------
package cc20_pkg;

   localparam int WORD_BYTES  = 8;
   localparam int WORD_W      = 64;
   localparam int COUNT_W     = 4;
   localparam int CTR_W       = 32;
   localparam int WPOS_W      = 3;
   localparam int BLOCK_WORDS = 8;
   localparam int REQ_DATA_W  = 72;
   localparam int QDEPTH      = 2;
   localparam int QPTR_W      = $clog2(QDEPTH);
   localparam int QCNT_W      = $clog2(QDEPTH + 1);
   localparam int REG_IDX_W   = 3;
   localparam int CSR_ADDR_W  = 6;

   localparam logic [REG_IDX_W-1:0] REG_KEY0     = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_KEY1     = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_KEY2     = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_KEY3     = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_NONCE_LO = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_NONCE_HI = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_START    = 3'd6;

   localparam logic [31:0] SIGMA0 = 32'h61707865;
   localparam logic [31:0] SIGMA1 = 32'h3320646e;
   localparam logic [31:0] SIGMA2 = 32'h79622d32;
   localparam logic [31:0] SIGMA3 = 32'h6b206574;

   typedef logic [15:0][31:0] words_type;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [31:0] d;
   } quad_type;

   typedef struct packed {
      logic [3:0][63:0] key;
      logic [63:0]      nonce_lo;
      logic [31:0]      nonce_hi;
      logic [31:0]      start_counter;
   } cfg_type;

   typedef struct packed {
      logic [WORD_W-1:0]     plain;
      logic [WORD_BYTES-1:0] mask;
      logic                  last;
      logic                  need_block;
      logic [CTR_W-1:0]      ctr;
      logic [WPOS_W-1:0]     wpos;
   } entry_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_ROUND,
      BK_ADD,
      BK_EMIT
   } back_state_type;

   function automatic logic [31:0] rotl(logic [31:0] v, int n);
      return (v << n) | (v >> (32 - n));
   endfunction

   function automatic quad_type quarter(quad_type q);
      quad_type r;
      r = q;
      r.a = r.a + r.b; r.d = rotl(r.d ^ r.a, 16);
      r.c = r.c + r.d; r.b = rotl(r.b ^ r.c, 12);
      r.a = r.a + r.b; r.d = rotl(r.d ^ r.a, 8);
      r.c = r.c + r.d; r.b = rotl(r.b ^ r.c, 7);
      return r;
   endfunction

   function automatic words_type apply_quarter(words_type w, int a, int b, int c, int d);
      words_type r;
      quad_type  q;
      r = w;
      q = quarter('{a: w[a], b: w[b], c: w[c], d: w[d]});
      r[a] = q.a;
      r[b] = q.b;
      r[c] = q.c;
      r[d] = q.d;
      return r;
   endfunction

   function automatic words_type column_round(words_type w);
      words_type r;
      r = apply_quarter(w, 0, 4, 8, 12);
      r = apply_quarter(r, 1, 5, 9, 13);
      r = apply_quarter(r, 2, 6, 10, 14);
      r = apply_quarter(r, 3, 7, 11, 15);
      return r;
   endfunction

   function automatic words_type diagonal_round(words_type w);
      words_type r;
      r = apply_quarter(w, 0, 5, 10, 15);
      r = apply_quarter(r, 1, 6, 11, 12);
      r = apply_quarter(r, 2, 7, 8, 13);
      r = apply_quarter(r, 3, 4, 9, 14);
      return r;
   endfunction

   function automatic words_type make_init(cfg_type c, logic [CTR_W-1:0] ctr);
      words_type w;
      w[0] = SIGMA0;
      w[1] = SIGMA1;
      w[2] = SIGMA2;
      w[3] = SIGMA3;
      for (int j = 0; j < 4; j++) begin
         w[4 + 2 * j] = c.key[j][31:0];
         w[5 + 2 * j] = c.key[j][63:32];
      end
      w[12] = ctr;
      w[13] = c.nonce_lo[31:0];
      w[14] = c.nonce_lo[63:32];
      w[15] = c.nonce_hi;
      return w;
   endfunction

endpackage
`default_nettype wire

@@ design/chacha20_stream_cipher.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chacha20_stream_cipher
// ChaCha20 (IETF) stream cipher over 8-byte words with an APB register port.
// ----------------------------------------------------------------------------
// operation: a word that opens a keystream block loads the initial state,
//    runs 2*DOUBLE_ROUNDS rounds, one column or diagonal round per cycle,
//    adds the initial state into the keystream store and then gives its
//    registered result; other words use the stored keystream directly
// reset: clears message position, block counter, queue, output valid and the
//    configuration registers; the keystream store is not cleared
module chacha20_stream_cipher #(
   parameter int DOUBLE_ROUNDS = 10
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_tvalid,
   output logic                               req_tready,
   // plain_bytes [63:0], byte_count [67:64], zero fill [71:68]
   input  wire  [cc20_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  wire                                req_tlast,
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   // cipher_bytes [63:0]
   output logic [cc20_pkg::WORD_W-1:0]        rsp_tdata,
   output logic                               rsp_tlast,
   input  wire                                csr_psel,
   input  wire                                csr_penable,
   input  wire                                csr_pwrite,
   input  wire  [cc20_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire  [63:0]                        csr_pwdata,
   output logic [63:0]                        csr_prdata,
   output logic                               csr_pready
);

   cc20_pkg::cfg_type               cfg_ff, cfg_in;
   logic [cc20_pkg::REG_IDX_W-1:0]  reg_idx;
   logic                            csr_write;
   logic                            push;
   logic                            pop;
   logic                            queue_full;
   logic                            queue_empty;
   cc20_pkg::entry_type             push_entry;
   cc20_pkg::entry_type             head;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[5:3];
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (reg_idx)
            cc20_pkg::REG_KEY0:     cfg_in.key[0]        = csr_pwdata;
            cc20_pkg::REG_KEY1:     cfg_in.key[1]        = csr_pwdata;
            cc20_pkg::REG_KEY2:     cfg_in.key[2]        = csr_pwdata;
            cc20_pkg::REG_KEY3:     cfg_in.key[3]        = csr_pwdata;
            cc20_pkg::REG_NONCE_LO: cfg_in.nonce_lo      = csr_pwdata;
            cc20_pkg::REG_NONCE_HI: cfg_in.nonce_hi      = csr_pwdata[31:0];
            cc20_pkg::REG_START:    cfg_in.start_counter = csr_pwdata[31:0];
            default:                cfg_in               = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         cc20_pkg::REG_KEY0:     csr_prdata = cfg_ff.key[0];
         cc20_pkg::REG_KEY1:     csr_prdata = cfg_ff.key[1];
         cc20_pkg::REG_KEY2:     csr_prdata = cfg_ff.key[2];
         cc20_pkg::REG_KEY3:     csr_prdata = cfg_ff.key[3];
         cc20_pkg::REG_NONCE_LO: csr_prdata = cfg_ff.nonce_lo;
         cc20_pkg::REG_NONCE_HI: csr_prdata = {32'd0, cfg_ff.nonce_hi};
         cc20_pkg::REG_START:    csr_prdata = {32'd0, cfg_ff.start_counter};
         default:                csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cc20_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .start_counter (cfg_ff.start_counter),
      .queue_full    (queue_full),
      .push          (push),
      .push_entry    (push_entry)
   );

   cc20_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head       (head),
      .empty      (queue_empty)
   );

   cc20_back #(
      .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head       (head),
      .empty      (queue_empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

@@ design/cc20_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cc20_front
// Accepts plaintext words, tracks message position and block counter, and
// marks the words that need a fresh keystream block.
// ----------------------------------------------------------------------------
module cc20_front (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_tvalid,
   output logic                             req_tready,
   // plain_bytes [63:0], byte_count [67:64], zero fill [71:68]
   input  wire  [cc20_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  wire                              req_tlast,
   input  wire  [cc20_pkg::CTR_W-1:0]       start_counter,
   input  wire                              queue_full,
   output logic                             push,
   output cc20_pkg::entry_type              push_entry
);

   logic                          msg_start_ff, msg_start_in;
   logic [cc20_pkg::WPOS_W-1:0]   wpos_ff, wpos_in;
   logic [cc20_pkg::CTR_W-1:0]    ctr_ff, ctr_in;
   logic [cc20_pkg::CTR_W-1:0]    ctr_use;
   logic [cc20_pkg::WPOS_W-1:0]   wpos_use;
   logic [cc20_pkg::COUNT_W-1:0]  count;
   logic [cc20_pkg::WORD_BYTES-1:0] mask;

   assign req_tready = ~queue_full;
   assign push       = req_tvalid & ~queue_full;
   assign count      = req_tdata[cc20_pkg::WORD_W +: cc20_pkg::COUNT_W];
   assign ctr_use    = msg_start_ff ? start_counter : ctr_ff;
   assign wpos_use   = msg_start_ff ? '0 : wpos_ff;

   always_comb begin
      for (int i = 0; i < cc20_pkg::WORD_BYTES; i++) begin
         mask[i] = ~req_tlast || (count > cc20_pkg::COUNT_W'(i));
      end
   end

   always_comb begin
      push_entry.plain      = req_tdata[cc20_pkg::WORD_W-1:0];
      push_entry.mask       = mask;
      push_entry.last       = req_tlast;
      push_entry.need_block = (wpos_use == '0);
      push_entry.ctr        = ctr_use;
      push_entry.wpos       = wpos_use;
   end

   always_comb begin
      msg_start_in = msg_start_ff;
      wpos_in      = wpos_ff;
      ctr_in       = ctr_ff;
      if (push) begin
         ctr_in = (wpos_use == '0) ? ctr_use + 1'b1 : ctr_use;
         if (req_tlast) begin
            msg_start_in = 1'b1;
            wpos_in      = '0;
         end else begin
            msg_start_in = 1'b0;
            wpos_in      = wpos_use + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         msg_start_ff <= 1'b1;
         wpos_ff      <= '0;
         ctr_ff       <= '0;
      end else begin
         msg_start_ff <= msg_start_in;
         wpos_ff      <= wpos_in;
         ctr_ff       <= ctr_in;
      end
   end

endmodule
`default_nettype wire

@@ design/cc20_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cc20_queue
// Short first-in first-out queue of classified words between front and back.
// ----------------------------------------------------------------------------
module cc20_queue (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push,
   input  cc20_pkg::entry_type  push_entry,
   output logic                 full,
   input  wire                  pop,
   output cc20_pkg::entry_type  head,
   output logic                 empty
);

   cc20_pkg::entry_type            entries_ff [cc20_pkg::QDEPTH];
   logic [cc20_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [cc20_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [cc20_pkg::QCNT_W-1:0]    count_ff, count_in;

   assign full  = (count_ff == cc20_pkg::QCNT_W'(cc20_pkg::QDEPTH));
   assign empty = (count_ff == '0);
   assign head  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == cc20_pkg::QPTR_W'(cc20_pkg::QDEPTH - 1)) ? '0
                     : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == cc20_pkg::QPTR_W'(cc20_pkg::QDEPTH - 1)) ? '0
                     : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

@@ design/cc20_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cc20_back
// Runs the ChaCha20 rounds one column or diagonal round per cycle, holds the
// keystream block and produces the registered cipher words.
// ----------------------------------------------------------------------------
module cc20_back #(
   parameter int DOUBLE_ROUNDS = 10
) (
   input  wire                              clock,
   input  wire                              reset,
   input  cc20_pkg::cfg_type                cfg,
   input  cc20_pkg::entry_type              head,
   input  wire                              empty,
   output logic                             pop,
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   // cipher_bytes [63:0]
   output logic [cc20_pkg::WORD_W-1:0]      rsp_tdata,
   output logic                             rsp_tlast
);

   localparam int HALF_ROUNDS = 2 * DOUBLE_ROUNDS;
   localparam int RND_W       = $clog2(HALF_ROUNDS);

   cc20_pkg::back_state_type       state_ff, state_in;
   logic [RND_W-1:0]               rnd_ff, rnd_in;
   cc20_pkg::words_type            w_ff, w_in;
   logic [cc20_pkg::BLOCK_WORDS-1:0][cc20_pkg::WORD_W-1:0] ks_ff, ks_in;
   logic                           valid_ff, valid_in;
   logic [cc20_pkg::WORD_W-1:0]    data_ff, data_in;
   logic                           last_ff, last_in;
   cc20_pkg::words_type            init;
   logic [cc20_pkg::WORD_W-1:0]    byte_keep;
   logic                           slot_free;

   assign init       = cc20_pkg::make_init(cfg, head.ctr);
   assign slot_free  = ~valid_ff | rsp_tready;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

   always_comb begin
      for (int i = 0; i < cc20_pkg::WORD_BYTES; i++) begin
         byte_keep[8 * i +: 8] = {8{head.mask[i]}};
      end
   end

   always_comb begin
      state_in = state_ff;
      rnd_in   = rnd_ff;
      w_in     = w_ff;
      ks_in    = ks_ff;
      pop      = 1'b0;
      valid_in = valid_ff & ~rsp_tready;
      data_in  = data_ff;
      last_in  = last_ff;
      case (state_ff)
         cc20_pkg::BK_IDLE: begin
            if (!empty) begin
               if (head.need_block) begin
                  w_in     = init;
                  rnd_in   = '0;
                  state_in = cc20_pkg::BK_ROUND;
               end else if (slot_free) begin
                  pop      = 1'b1;
                  valid_in = 1'b1;
                  data_in  = (head.plain ^ ks_ff[head.wpos]) & byte_keep;
                  last_in  = head.last;
               end
            end
         end
         cc20_pkg::BK_ROUND: begin
            w_in = rnd_ff[0] ? cc20_pkg::diagonal_round(w_ff)
                             : cc20_pkg::column_round(w_ff);
            if (rnd_ff == RND_W'(HALF_ROUNDS - 1)) begin
               state_in = cc20_pkg::BK_ADD;
            end else begin
               rnd_in = rnd_ff + 1'b1;
            end
         end
         cc20_pkg::BK_ADD: begin
            for (int k = 0; k < cc20_pkg::BLOCK_WORDS; k++) begin
               ks_in[k] = {w_ff[2 * k + 1] + init[2 * k + 1], w_ff[2 * k] + init[2 * k]};
            end
            state_in = cc20_pkg::BK_EMIT;
         end
         cc20_pkg::BK_EMIT: begin
            if (slot_free) begin
               pop      = 1'b1;
               valid_in = 1'b1;
               data_in  = (head.plain ^ ks_ff[head.wpos]) & byte_keep;
               last_in  = head.last;
               state_in = cc20_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = cc20_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cc20_pkg::BK_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rnd_ff  <= rnd_in;
      w_ff    <= w_in;
      ks_ff   <= ks_in;
      data_ff <= data_in;
      last_ff <= last_in;
   end

endmodule
`default_nettype wire
